FILE: hdl/pcxrle_pkg.sv
// Shared types and constants for the PCX run-length scanline decoder.
// No dependencies; used by pcxrle_ctrl, pcxrle_dp and the top level.
package pcxrle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COL_W   = 16;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned LINE_W  = 16;
    localparam int unsigned LCNT_W  = 17;
    localparam int unsigned PCNT_W  = 3;
    localparam int unsigned POS_W   = 18;
    localparam int unsigned RUN_W   = 6;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned CIDX_W  = 2;

    // Top two bits set marks a run escape; low six bits carry the count
    localparam logic [BYTE_W-1:0] ESCAPE_MARK = 8'hC0;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_RLE_ENABLE     = 2'd0,
        REG_BYTES_PER_LINE = 2'd1,
        REG_PLANE_COUNT    = 2'd2,
        REG_LINE_COUNT     = 2'd3
    } t_cfg_reg;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // input transfer this cycle
        logic emit;   // write one decoded byte to the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic load_emits;  // the byte being taken produces at least one result
        logic out_space;   // output register free or being drained
        logic emit_last;   // the byte about to be emitted ends this input's results
    } t_status;

endpackage

FILE: hdl/pcxrle_ctrl.sv
// Controller for the PCX run-length decoder: takes input bytes and sequences
// run expansion. Depends on pcxrle_pkg.
module pcxrle_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_data_valid,
    output logic                o_data_ready,
    input  pcxrle_pkg::t_status i_status,
    output pcxrle_pkg::t_cmd    o_cmd
);
    import pcxrle_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_data_valid && i_status.load_emits) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_status.out_space && i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_data_ready = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_data_ready = 1'b1;
                o_cmd.load   = i_data_valid;
            end
            S_RUN: begin
                o_cmd.emit = i_status.out_space;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/pcxrle_dp.sv
// Datapath for the PCX run-length decoder: configuration registers, escape
// state, scanline counters and the output register. Depends on pcxrle_pkg.
module pcxrle_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxrle_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [pcxrle_pkg::BYTE_W-1:0]       i_data_byte,
    input  pcxrle_pkg::t_cmd                    i_cmd,
    output pcxrle_pkg::t_status                 o_status,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [pcxrle_pkg::LINE_W-1:0]       o_line_index,
    output logic [pcxrle_pkg::POS_W-1:0]        o_byte_position,
    output logic [pcxrle_pkg::BYTE_W-1:0]       o_pixel_byte,
    output logic                                o_last_of_run,
    output logic                                o_last_of_image
);
    import pcxrle_pkg::*;

    // Configuration
    logic              r_rle;
    logic [COL_W-1:0]  r_bpl;
    logic [PCNT_W-1:0] r_planes;
    logic [LCNT_W-1:0] r_lines;

    // Decode state
    logic              r_esc_pending;
    logic [RUN_W-1:0]  r_pend_cnt;
    logic [RUN_W-1:0]  r_remain;
    logic [BYTE_W-1:0] r_byte;
    logic [COL_W-1:0]  r_col;
    logic [PLANE_W-1:0] r_plane;
    logic [LINE_W-1:0] r_line;
    logic              r_done;

    // Output register
    logic              r_o_valid;
    logic [LINE_W-1:0] r_o_line;
    logic [POS_W-1:0]  r_o_pos;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_lor;
    logic              r_o_loi;

    logic [COL_W-1:0]   bpl_m1;
    logic [PLANE_W-1:0] planes_m1;
    logic [PCNT_W-1:0]  planes_eff;
    logic [LINE_W-1:0]  lines_m1;
    logic               is_escape;
    logic               end_plane;
    logic               end_line;
    logic               end_img;
    logic [POS_W-1:0]   pos;

    // Effective limits: zero means one, planes clip at four, lines at 65536
    always_comb begin
        bpl_m1 = (r_bpl == '0) ? '0 : r_bpl - COL_W'(1);
        if (r_planes == '0) begin
            planes_eff = PCNT_W'(1);
        end else if (r_planes > PCNT_W'(4)) begin
            planes_eff = PCNT_W'(4);
        end else begin
            planes_eff = r_planes;
        end
        planes_m1 = PLANE_W'(planes_eff - PCNT_W'(1));
        if (r_lines == '0) begin
            lines_m1 = '0;
        end else if (r_lines > LCNT_W'(65536)) begin
            lines_m1 = '1;
        end else begin
            lines_m1 = LINE_W'(r_lines - LCNT_W'(1));
        end
    end

    // Position and end-of-plane/line/image detection for the next emitted byte
    assign end_plane = (r_col >= bpl_m1);
    assign end_line  = end_plane && (r_plane >= planes_m1);
    assign end_img   = end_line && (r_line >= lines_m1);
    assign pos       = POS_W'(r_col) * POS_W'(planes_eff) + POS_W'(r_plane);

    assign is_escape = r_rle && ((i_data_byte & ESCAPE_MARK) == ESCAPE_MARK);

    // Status to the controller
    always_comb begin
        o_status.load_emits = !r_done &&
                              (r_esc_pending ? (r_pend_cnt != '0) : !is_escape);
        o_status.out_space  = !r_o_valid || i_res_ready;
        o_status.emit_last  = end_line || (r_remain == RUN_W'(1));
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rle    <= 1'b1;
            r_bpl    <= COL_W'(1);
            r_planes <= PCNT_W'(1);
            r_lines  <= LCNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_RLE_ENABLE:     r_rle    <= i_cfg_wdata[0];
                REG_BYTES_PER_LINE: r_bpl    <= i_cfg_wdata[COL_W-1:0];
                REG_PLANE_COUNT:    r_planes <= i_cfg_wdata[PCNT_W-1:0];
                REG_LINE_COUNT:     r_lines  <= i_cfg_wdata[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input decode and scanline counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_pending <= 1'b0;
            r_pend_cnt    <= '0;
            r_remain      <= '0;
            r_col         <= '0;
            r_plane       <= '0;
            r_line        <= '0;
            r_done        <= 1'b0;
        end else if (i_cmd.load) begin
            if (!r_done) begin
                if (r_esc_pending) begin
                    r_esc_pending <= 1'b0;
                    r_remain      <= r_pend_cnt;
                    r_pend_cnt    <= '0;
                end else if (is_escape) begin
                    r_esc_pending <= 1'b1;
                    r_pend_cnt    <= i_data_byte[RUN_W-1:0];
                end else begin
                    r_remain <= RUN_W'(1);
                end
            end
        end else if (i_cmd.emit) begin
            r_remain <= r_remain - RUN_W'(1);
            if (end_img) begin
                r_done <= 1'b1;
            end else if (end_line) begin
                r_col   <= '0;
                r_plane <= '0;
                r_line  <= r_line + LINE_W'(1);
            end else if (end_plane) begin
                r_col   <= '0;
                r_plane <= r_plane + PLANE_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Held byte value for the run
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_line <= r_line;
            r_o_pos  <= pos;
            r_o_byte <= r_byte;
            r_o_lor  <= o_status.emit_last;
            r_o_loi  <= end_img;
        end
    end

    assign o_res_valid     = r_o_valid;
    assign o_line_index    = r_o_line;
    assign o_byte_position = r_o_pos;
    assign o_pixel_byte    = r_o_byte;
    assign o_last_of_run   = r_o_lor;
    assign o_last_of_image = r_o_loi;

endmodule

FILE: hdl/pcx_rle_scanline_decoder.sv
// PCX run-length scanline decoder, top level. An input byte is held on its
// transfer, and its results are written to the output register from the run
// state, which waits while the output register is full. No new input byte is
// taken until the run is done. An escape byte is taken on its own; its value
// byte then expands one byte a cycle while the output is not stalled.
// Synchronous active-low reset restores register defaults and clears the decode state.
module pcx_rle_scanline_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxrle_pkg::CIDX_W-1:0]       i_cfg_index,
    input  logic [pcxrle_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                                i_data_valid,
    output logic                                o_data_ready,
    input  logic [pcxrle_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic [pcxrle_pkg::LINE_W-1:0]       o_line_index,
    output logic [pcxrle_pkg::POS_W-1:0]        o_byte_position,
    output logic [pcxrle_pkg::BYTE_W-1:0]       o_pixel_byte,
    output logic                                o_last_of_run,
    output logic                                o_last_of_image
);
    import pcxrle_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer
    pcxrle_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_data_valid (i_data_valid),
        .o_data_ready (o_data_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    // Counters, configuration and output register
    pcxrle_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_data_byte     (i_data_byte),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_line_index    (o_line_index),
        .o_byte_position (o_byte_position),
        .o_pixel_byte    (o_pixel_byte),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_image (o_last_of_image)
    );

endmodule
